FILE: rtl/cqf_pkg.sv
// shared types, constants and helpers for the circular queue
package cqf_pkg;

  localparam int DEPTH       = 8;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int WORD_W      = 32;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - WORD_W - STATUS_W;

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [WORD_W-1:0]  word_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_DISP = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_HOLD,
    FSM_EMIT
  } fsm_t;

  typedef struct packed {
    logic  wr_en;
    idx_t  wr_addr;
    word_t wr_data;
    logic  rd_en;
    idx_t  rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic    load;
    word_t   word;
    status_t status;
    logic    last;
  } res_t;

  function automatic idx_t ring_next(idx_t i);
    ring_next = (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
  endfunction

endpackage

FILE: rtl/cqf_mem.sv
// slot storage: one write port, one read port with registered read data
module cqf_mem (
  input  logic              clk,
  input  cqf_pkg::mem_req_t req,
  output cqf_pkg::word_t    rd_data
);
  import cqf_pkg::*;

  word_t slots [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      slots[req.wr_addr] <= req.wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= slots[req.rd_addr];
    end
  end

endmodule

FILE: rtl/cqf_ctrl.sv
// queue controller: head/tail bookkeeping, memory requests and result sequencing
module cqf_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [cqf_pkg::KIND_W-1:0] in_kind,
  input  cqf_pkg::word_t           in_value,
  input  cqf_pkg::word_t           rd_data,
  input  logic                     out_free,
  output cqf_pkg::mem_req_t        mem_req,
  output cqf_pkg::res_t            res
);
  import cqf_pkg::*;

  fsm_t    state, state_next;
  idx_t    head, head_next;
  idx_t    tail, tail_next;
  logic    is_empty, is_empty_next;
  idx_t    cursor, cursor_next;
  idx_t    cnt, cnt_next;
  logic    op_disp, op_disp_next;
  status_t pend_status, pend_status_next;

  logic    accept;
  logic    full;
  logic    imm;
  status_t imm_status;
  logic    go_emit;
  logic    fin;

  assign in_ready = (state == FSM_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = !is_empty && (ring_next(tail) == head);
  assign fin      = !op_disp || (cursor == tail) || (cnt == idx_t'(DEPTH - 1));

  // decode of the incoming operation
  always_comb begin
    imm        = 1'b0;
    imm_status = STAT_OK;
    go_emit    = 1'b0;
    if (accept) begin
      unique case (kind_t'(in_kind))
        KIND_ENQ: begin
          imm        = 1'b1;
          imm_status = full ? STAT_FULL : STAT_OK;
        end
        KIND_DEQ, KIND_DISP: begin
          if (is_empty) begin
            imm        = 1'b1;
            imm_status = STAT_EMPTY;
          end else begin
            go_emit = 1'b1;
          end
        end
        default: begin
          imm = 1'b0;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (go_emit) begin
          state_next = FSM_EMIT;
        end else if (imm && !out_free) begin
          state_next = FSM_HOLD;
        end
      end
      FSM_HOLD: begin
        if (out_free) state_next = FSM_IDLE;
      end
      FSM_EMIT: begin
        if (out_free && fin) state_next = FSM_IDLE;
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    mem_req          = '0;
    res              = '0;
    res.status       = STAT_OK;
    head_next        = head;
    tail_next        = tail;
    is_empty_next    = is_empty;
    cursor_next      = cursor;
    cnt_next         = cnt;
    op_disp_next     = op_disp;
    pend_status_next = pend_status;

    unique case (state)
      FSM_IDLE: begin
        if (accept && kind_t'(in_kind) == KIND_ENQ) begin
          if (is_empty) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = '0;
            mem_req.wr_data = in_value;
            head_next       = '0;
            tail_next       = '0;
            is_empty_next   = 1'b0;
          end else if (!full) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ring_next(tail);
            mem_req.wr_data = in_value;
            tail_next       = ring_next(tail);
          end
        end
        if (go_emit) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = head;
          cursor_next     = head;
          cnt_next        = '0;
          op_disp_next    = (kind_t'(in_kind) == KIND_DISP);
          if (kind_t'(in_kind) == KIND_DEQ) begin
            if (head == tail) begin
              is_empty_next = 1'b1;
              head_next     = '0;
              tail_next     = '0;
            end else begin
              head_next = ring_next(head);
            end
          end
        end
        if (imm) begin
          if (out_free) begin
            res.load   = 1'b1;
            res.status = imm_status;
            res.last   = 1'b1;
          end else begin
            pend_status_next = imm_status;
          end
        end
      end
      FSM_HOLD: begin
        if (out_free) begin
          res.load   = 1'b1;
          res.status = pend_status;
          res.last   = 1'b1;
        end
      end
      FSM_EMIT: begin
        if (out_free) begin
          res.load = 1'b1;
          res.word = rd_data;
          res.last = fin;
          if (!fin) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ring_next(cursor);
            cursor_next     = ring_next(cursor);
            cnt_next        = cnt + idx_t'(1);
          end
        end
      end
      default: begin
        res.load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FSM_IDLE;
      head     <= '0;
      tail     <= '0;
      is_empty <= 1'b1;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      is_empty <= is_empty_next;
    end
  end

  always_ff @(posedge clk) begin
    cursor      <= cursor_next;
    cnt         <= cnt_next;
    op_disp     <= op_disp_next;
    pend_status <= pend_status_next;
  end

endmodule

FILE: rtl/circular_queue_fifo_core.sv
// top level of the circular queue: controller, slot memory and output register
//
//  channel   dir  tdata                          tuser        tlast
//  s_*       in   [31:0] push_value              [1:0] kind   -
//  m_*       out  [31:0] word_out, [33:32] status -           last
//
//  enqueue and every error result are loaded when taken if the output is free;
//  the next transaction is taken the cycle after
//  dequeue reads the head slot through the registered read port, then emits it
//  display gives one word per cycle while output is free, up to DEPTH words
//  reset clears head, tail and the empty flag; slot contents are not cleared
//  a stalled output holds the controller: the pending result or read word waits
module circular_queue_fifo_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] push_value
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] word_out, [33:32] status, rest zero
  output logic        m_tlast    // last
);
  import cqf_pkg::*;

  mem_req_t mem_req;
  res_t     res;
  word_t    rd_data;
  logic     out_free;

  // output register is free when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;

  cqf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (s_tuser),
    .in_value (word_t'(s_tdata)),
    .rd_data  (rd_data),
    .out_free (out_free),
    .mem_req  (mem_req),
    .res      (res)
  );

  cqf_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // output register, parts the controller from the downstream stall
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, res.status, res.word};
      m_tlast <= res.last;
    end
  end

  // a result is only loaded when the output register can take it
  a_load_free : assert property (@(posedge clk) disable iff (rst)
    res.load |-> out_free)
    else $error("result loaded into a busy output register");

  // memory never reads and writes in the same cycle
  a_no_rw : assert property (@(posedge clk) disable iff (rst)
    !(mem_req.wr_en && mem_req.rd_en))
    else $error("slot memory read and write in the same cycle");

  // an accepted enqueue always leaves a result waiting at the output
  a_enq_result : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == KIND_ENQ) |=> m_tvalid)
    else $error("enqueue transaction gave no result");

endmodule

FILE: test/tb.sv
// self-checking testbench for the circular queue: directed table, random traffic, stalls
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cqf_pkg::*;

  localparam int N_RANDOM     = 148;
  localparam int HOLD_CYCLES  = 64;    // long output hold-off, fills the block up
  localparam int STALL_LIMIT  = 1000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 32;    // covers a full display burst plus the read
  localparam int MAX_REPORTS  = 10;

  // kind code the block must swallow without a result
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    word_t   word;
    status_t status;
    logic    last;
  } q_result_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    word_t             value;
    logic              typed;  // expectation written in the table, not predicted
    q_result_t         want;
  } q_op_t;

  localparam q_result_t R_OK    = '{word: '0, status: STAT_OK,    last: 1'b1};
  localparam q_result_t R_FULL  = '{word: '0, status: STAT_FULL,  last: 1'b1};
  localparam q_result_t R_EMPTY = '{word: '0, status: STAT_EMPTY, last: 1'b1};
  localparam q_result_t R_NONE  = '0;

  localparam int N_DIR = 22;

  // directed rows: empty queue errors, dequeue of the only entry, fill to full with the
  // word extremes, enqueue into a full queue, display of a full and of a wrapped queue,
  // and an unused kind that gives nothing back
  localparam q_op_t DIR_TAB [N_DIR] = '{
    '{KIND_DEQ,    32'h0000_0000, 1'b1, R_EMPTY},
    '{KIND_DISP,   32'h0000_0000, 1'b1, R_EMPTY},
    '{KIND_ENQ,    32'h7FFF_FFFF, 1'b1, R_OK},
    '{KIND_DEQ,    32'h0000_0000, 1'b0, R_NONE},
    '{KIND_DEQ,    32'hFFFF_FFFF, 1'b1, R_EMPTY},
    '{KIND_DISP,   32'hFFFF_FFFF, 1'b1, R_EMPTY},
    '{KIND_ENQ,    32'h7FFF_FFFF, 1'b1, R_OK},
    '{KIND_ENQ,    32'h8000_0000, 1'b1, R_OK},
    '{KIND_ENQ,    32'hFFFF_FFFF, 1'b1, R_OK},
    '{KIND_ENQ,    32'h0000_0000, 1'b1, R_OK},
    '{KIND_ENQ,    32'h0000_0001, 1'b1, R_OK},
    '{KIND_ENQ,    32'h5555_5555, 1'b1, R_OK},
    '{KIND_ENQ,    32'hAAAA_AAAA, 1'b1, R_OK},
    '{KIND_ENQ,    32'h1234_5678, 1'b1, R_OK},
    '{KIND_ENQ,    32'h0BAD_F00D, 1'b1, R_FULL},
    '{KIND_DISP,   32'h0000_0000, 1'b0, R_NONE},
    '{KIND_DEQ,    32'h0000_0000, 1'b0, R_NONE},
    '{KIND_DEQ,    32'h0000_0000, 1'b0, R_NONE},
    '{KIND_ENQ,    32'hDEAD_BEEF, 1'b1, R_OK},
    '{KIND_ENQ,    32'h0000_002A, 1'b1, R_OK},
    '{KIND_DISP,   32'h0000_0000, 1'b0, R_NONE},
    '{KIND_UNUSED, 32'hFFFF_FFFF, 1'b0, R_NONE}
  };

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [31:0]            s_tdata;   // [31:0] push_value
  logic [1:0]             s_tuser;   // [1:0] kind
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [31:0] word_out, [33:32] status, rest zero
  logic                   m_tlast;   // last

  circular_queue_fifo_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  q_op_t     ops [$];        // whole stimulus, directed rows first
  q_result_t queued_res [$]; // results still owed by the block
  int        taken;          // operations accepted so far, seen by the input monitor
  int        fails;
  int        src_idle;       // percentage of cycles the sender holds back
  int        snk_idle;       // percentage of cycles the receiver stalls
  logic      hold_req;
  int        quiet;

  // shadow of the queue contents and pointers
  word_t     ring_mem [DEPTH];
  idx_t      ring_head;
  idx_t      ring_tail;
  logic      ring_vacant;
  q_result_t step_res [DEPTH];
  int        n_res;

  function automatic idx_t ring_succ(idx_t i);
    return idx_t'((int'(i) + 1) % DEPTH);
  endfunction

  function automatic q_result_t mk_res(word_t w, status_t s, logic l);
    q_result_t r;
    r.word   = w;
    r.status = s;
    r.last   = l;
    return r;
  endfunction

  // applies one operation to the shadow queue, leaves its results in step_res
  function automatic int queue_step(logic [KIND_W-1:0] kind, word_t value);
    int   n;
    idx_t i;
    logic fin;
    n = 0;
    case (kind)
      KIND_ENQ: begin
        if (ring_vacant) begin
          // first entry always lands in slot zero
          ring_head   = '0;
          ring_tail   = '0;
          ring_mem[0] = value;
          ring_vacant = 1'b0;
          step_res[0] = mk_res('0, STAT_OK, 1'b1);
        end else if (ring_succ(ring_tail) == ring_head) begin
          step_res[0] = mk_res('0, STAT_FULL, 1'b1);
        end else begin
          ring_tail           = ring_succ(ring_tail);
          ring_mem[ring_tail] = value;
          step_res[0]         = mk_res('0, STAT_OK, 1'b1);
        end
        n = 1;
      end
      KIND_DEQ: begin
        if (ring_vacant) begin
          step_res[0] = mk_res('0, STAT_EMPTY, 1'b1);
        end else begin
          step_res[0] = mk_res(ring_mem[ring_head], STAT_OK, 1'b1);
          if (ring_head == ring_tail) begin
            ring_vacant = 1'b1;
            ring_head   = '0;
            ring_tail   = '0;
          end else begin
            ring_head = ring_succ(ring_head);
          end
        end
        n = 1;
      end
      KIND_DISP: begin
        if (ring_vacant) begin
          step_res[0] = mk_res('0, STAT_EMPTY, 1'b1);
          n = 1;
        end else begin
          i = ring_head;
          while (n < DEPTH) begin
            fin         = (i == ring_tail) || (n == DEPTH - 1);
            step_res[n] = mk_res(ring_mem[i], STAT_OK, fin);
            n++;
            if (fin) break;
            i = ring_succ(i);
          end
        end
      end
      default: n = 0;
    endcase
    return n;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input side monitor: every accepted transaction advances the shadow queue
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      n_res = queue_step(s_tuser, s_tdata);
      if (ops[taken].typed) begin
        queued_res.push_back(ops[taken].want);
      end else begin
        for (int k = 0; k < n_res; k++) queued_res.push_back(step_res[k]);
      end
      taken++;
    end
  end

  // output side checker: oldest owed result against what the block hands over
  always @(posedge clk) begin
    q_result_t              got;
    logic [OUT_TDATA_W-1:0] want_tdata;
    if (!rst && m_tvalid && m_tready) begin
      if (queued_res.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("[%0t] unexpected result: tdata=%h tlast=%b", $realtime, m_tdata, m_tlast);
      end else begin
        got        = queued_res.pop_front();
        want_tdata = {{OUT_PAD_W{1'b0}}, got.status, got.word};
        if (m_tdata !== want_tdata || m_tlast !== got.last) begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("[%0t] mismatch: exp word %0d status %0d last %b",
                     $realtime, got.word, got.status, got.last);
            $display("  got word %0d status %0d last %b pad %h",
                     $signed(m_tdata[WORD_W-1:0]), m_tdata[WORD_W+STATUS_W-1:WORD_W],
                     m_tlast, m_tdata[OUT_TDATA_W-1:WORD_W+STATUS_W]);
          end
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("circular_queue_fifo_core regression: fail");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int     sent;
    int     mode;
    int     roll;
    int     phase;
    int     enq_lim;
    int     deq_lim;
    int     disp_lim;
    logic   fire;
    logic   hold_done;
    q_op_t  op;
    word_t  corner [4];

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    taken     = 0;
    fails     = 0;
    quiet     = 0;
    src_idle  = 0;
    snk_idle  = 0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    mode      = 0;
    ring_head   = '0;
    ring_tail   = '0;
    ring_vacant = 1'b1;
    corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000};

    foreach (DIR_TAB[k]) ops.push_back(DIR_TAB[k]);

    // random part in stretches that lean to filling, draining or a mix,
    // so full and empty are both reached over and over
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 16 == 0) mode = $urandom_range(2);
      case (mode)
        0:       begin enq_lim = 70; deq_lim = 85; disp_lim = 95; end
        1:       begin enq_lim = 15; deq_lim = 85; disp_lim = 95; end
        default: begin enq_lim = 40; deq_lim = 75; disp_lim = 95; end
      endcase
      roll = $urandom_range(99);
      if (roll < enq_lim)       op.kind = KIND_ENQ;
      else if (roll < deq_lim)  op.kind = KIND_DEQ;
      else if (roll < disp_lim) op.kind = KIND_DISP;
      else                      op.kind = KIND_UNUSED;
      op.value = ($urandom_range(7) == 0) ? corner[$urandom_range(3)] : word_t'($urandom);
      op.typed = 1'b0;
      op.want  = R_NONE;
      ops.push_back(op);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    sent = 0;
    while (sent < ops.size()) begin
      @(posedge clk);
      fire = s_tvalid && s_tready;
      if (fire) sent++;

      // idling phases: none, sender gaps, receiver stalls, both
      phase = (sent * 4) / ops.size();
      case (phase)
        0:       begin src_idle = 0;  snk_idle = 0;  end
        1:       begin src_idle = 58; snk_idle = 0;  end
        2:       begin src_idle = 0;  snk_idle = 58; end
        default: begin src_idle = 34; snk_idle = 34; end
      endcase
      if (!hold_done && sent == N_DIR + 8) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end

      // a held offer stays on the bus until it is taken
      if (!s_tvalid || fire) begin
        if (sent < ops.size() && $urandom_range(99) >= src_idle) begin
          s_tvalid <= 1'b1;
          s_tuser  <= ops[sent].kind;
          s_tdata  <= ops[sent].value;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end

    // let the input monitor log the final transaction first
    @(posedge clk);
    while (queued_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0 && queued_res.size() == 0) begin
      $display("circular_queue_fifo_core regression: pass");
    end else begin
      $display("circular_queue_fifo_core regression: fail");
    end
    $finish;
  end

endmodule
